// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Stand-alone header; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/h128fs_pkg.sv =====
// Types and constants for the Hamming(12,8) frame serializer.
// No dependencies.
package h128fs_pkg;

    localparam int FRAME_LEN = 20;
    localparam int SYNC_LEN  = 8;
    localparam int CODE_LEN  = 12;

    typedef logic [CODE_LEN-1:0] code_t;
    typedef logic [4:0]          pos_t;

    localparam pos_t SYNC_ONE_POS = pos_t'(SYNC_LEN - 1);
    localparam pos_t LAST_POS     = pos_t'(FRAME_LEN - 1);

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic last;
        pos_t pos;
        logic data;
        logic frame;
        logic strobe;
    } result_t;

endpackage

// ===== design/h128fs_front.sv =====
// Front end: accepts bytes and encodes them into 12-bit Hamming words.
// Depends on h128fs_pkg.
module h128fs_front
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  h128fs_pkg::q_status_t q_status,
    output logic                  push,
    output h128fs_pkg::code_t     push_code
);

    logic [7:0] d;

    // d[0] is the first data bit, which is bit 7 of the byte.
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            d[k] = s_tdata[7-k];
        end
    end

    // Bit 0 of the word is code position 1 and is sent first.
    always_comb
    begin
        push_code[0]  = d[0] ^ d[1] ^ d[3] ^ d[4] ^ d[6];
        push_code[1]  = d[0] ^ d[2] ^ d[3] ^ d[5] ^ d[6];
        push_code[2]  = d[0];
        push_code[3]  = d[1] ^ d[2] ^ d[3] ^ d[7];
        push_code[4]  = d[1];
        push_code[5]  = d[2];
        push_code[6]  = d[3];
        push_code[7]  = d[4] ^ d[5] ^ d[6] ^ d[7];
        push_code[8]  = d[4];
        push_code[9]  = d[5];
        push_code[10] = d[6];
        push_code[11] = d[7];
    end

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

endmodule

// ===== design/h128fs_queue.sv =====
// Small FIFO of encoded words between the front end and the serializer.
// Depends on h128fs_pkg.
module h128fs_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  h128fs_pkg::code_t     push_code,
    input  logic                  pop,
    output h128fs_pkg::code_t     pop_code,
    output h128fs_pkg::q_status_t q_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    h128fs_pkg::code_t mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              push_ok, pop_ok;

    assign q_status.full  = (count_reg == CW'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign push_ok        = push && !q_status.full;
    assign pop_ok         = pop && !q_status.empty;
    assign pop_code       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= push_code;
        end
    end

endmodule

// ===== design/h128fs_back.sv =====
// Back end: plays one encoded word out as a 20-period frame, one period a word.
// Depends on h128fs_pkg.
module h128fs_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  h128fs_pkg::q_status_t q_status,
    input  h128fs_pkg::code_t     pop_code,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output h128fs_pkg::result_t   result
);

    logic                 active_reg, active_next;
    h128fs_pkg::pos_t     pos_reg, pos_next;
    h128fs_pkg::code_t    code_reg, code_next;
    logic                 held_reg, held_next;
    logic                 in_code, is_last, advance;

    assign in_code = (pos_reg >= h128fs_pkg::pos_t'(h128fs_pkg::SYNC_LEN));
    assign is_last = (pos_reg == h128fs_pkg::LAST_POS);
    assign advance = active_reg && m_tready;
    // The next frame is loaded in the same cycle the last period is taken.
    assign pop     = !q_status.empty && (!active_reg || (advance && is_last));

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        code_next   = code_reg;
        held_next   = held_reg;
        if (advance)
        begin
            if (in_code)
            begin
                held_next = code_reg[0];
                code_next = code_reg >> 1;
            end
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        if (pop)
        begin
            active_next = 1'b1;
            pos_next    = '0;
            code_next   = pop_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
            held_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            held_reg   <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    always_comb
    begin
        m_tvalid      = active_reg;
        result.strobe = !in_code;
        result.frame  = (pos_reg != h128fs_pkg::SYNC_ONE_POS);
        result.data   = in_code ? code_reg[0] : held_reg;
        result.pos    = pos_reg;
        result.last   = is_last;
    end

endmodule

// ===== design/hamming_12_8_frame_serializer.sv =====
// Top level of the Hamming(12,8) frame serializer.
// Depends on h128fs_pkg, h128fs_front, h128fs_queue and h128fs_back.
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata) takes one data byte per
//   word. Each byte is encoded as Hamming(12,8) and sent on the master
//   channel as a frame of 20 words: eight sync periods with the strobe high
//   (the frame line low in the eighth), then the 12 code bits, position 1
//   first. m_tlast marks the twentieth word of each frame.
//   When the serializer is idle, an accepted byte is registered in the queue
//   and then loaded into the serializer's frame registers, which makes the
//   first word of its frame valid. One frame word goes out per cycle while
//   m_tready is high. Frames follow each other with no gap when bytes are waiting.
//   A queue of QUEUE_DEPTH encoded words lets the front end accept bytes
//   while a frame is still going out.
//   When the receiver holds m_tready low, the current word stays on the port
//   and the serializer waits; s_tready drops only once the queue is full.
//   Reset empties the queue, stops any frame in progress and sets the held
//   data line level to zero.
module hamming_12_8_frame_serializer
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] strobe_level, [1] frame_level, [2] data_level,
                                  // [7:3] bit_position
    output logic       m_tlast    // last_bit
);

    h128fs_pkg::q_status_t q_status;
    h128fs_pkg::code_t     push_code;
    h128fs_pkg::code_t     pop_code;
    h128fs_pkg::result_t   result;
    logic                  push;
    logic                  pop;

    h128fs_front u_front
    (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_status  (q_status),
        .push      (push),
        .push_code (push_code)
    );

    h128fs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_code (push_code),
        .pop       (pop),
        .pop_code  (pop_code),
        .q_status  (q_status)
    );

    h128fs_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_code (pop_code),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    assign m_tdata = {result.pos, result.data, result.frame, result.strobe};
    assign m_tlast = result.last;

endmodule

// ===== design/h128fs_checker.sv =====
// Port-level checks for the Hamming(12,8) frame serializer, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module h128fs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic       mid_taken;
    logic [4:0] pos;
    logic       sync_ok;
    logic       last_ok;

    assign mid_taken = m_tvalid && m_tready && !m_tlast;
    assign pos       = m_tdata[7:3];
    assign sync_ok   = (m_tdata[0] == (pos < 5'd8));
    assign last_ok   = (m_tlast == (pos == 5'd19));

    // A frame never pauses on the serializer's side once it has started.
    `ASSERT_NEXT(a_frame_no_gap, clk, rst_n, mid_taken, m_tvalid)

    // Periods within a frame count up by one.
    `ASSERT_NEXT(a_pos_step, clk, rst_n, mid_taken, pos == $past(pos) + 5'd1)

    // The strobe is high exactly in the sync periods, and the last word is period 19.
    `ASSERT_SAME(a_strobe_last, clk, rst_n, m_tvalid, sync_ok && last_ok)

    // A stalled word holds.
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind hamming_12_8_frame_serializer h128fs_checker u_h128fs_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the Hamming(12,8) frame serializer.
// It predicts every frame word from the bytes the block accepts and compares them in order.
// Depends on h128fs_pkg and hamming_12_8_frame_serializer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Expected frame words, oldest first.
    h128fs_pkg::result_t frame_words_due[$];
    logic       line_level;
    int         sender_idle_pct = 0;
    int         receiver_stall_pct = 0;
    int         error_count = 0;
    int         bytes_sent = 0;
    int         words_checked = 0;

    hamming_12_8_frame_serializer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Element 0 is code position 1; data bit 7 of the byte is d1.
    function automatic logic [11:0] hamming_code(input logic [7:0] b);
        logic [11:0] code;
        code[0]  = b[7] ^ b[6] ^ b[4] ^ b[3] ^ b[1];
        code[1]  = b[7] ^ b[5] ^ b[4] ^ b[2] ^ b[1];
        code[2]  = b[7];
        code[3]  = b[6] ^ b[5] ^ b[4] ^ b[0];
        code[4]  = b[6];
        code[5]  = b[5];
        code[6]  = b[4];
        code[7]  = b[3] ^ b[2] ^ b[1] ^ b[0];
        code[8]  = b[3];
        code[9]  = b[2];
        code[10] = b[1];
        code[11] = b[0];
        return code;
    endfunction

    // Queues the 20 words of one frame. The data line keeps its last level
    // through the sync periods.
    function automatic void predict_frame(input logic [7:0] b);
        logic [11:0]         code;
        h128fs_pkg::result_t w;
        code = hamming_code(b);
        for (int i = 0; i < h128fs_pkg::FRAME_LEN; i++)
        begin
            w.pos    = h128fs_pkg::pos_t'(i);
            w.last   = (w.pos == h128fs_pkg::LAST_POS);
            w.frame  = (w.pos != h128fs_pkg::SYNC_ONE_POS);
            w.strobe = (i < h128fs_pkg::SYNC_LEN);
            if (i >= h128fs_pkg::SYNC_LEN)
            begin
                line_level = code[i - h128fs_pkg::SYNC_LEN];
            end
            w.data = line_level;
            frame_words_due.push_back(w);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_level = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (frame_words_due.size() == 0)
                begin
                    $error("unexpected word: m_tdata %02h, m_tlast %0b", m_tdata, m_tlast);
                    error_count++;
                end
                else
                begin
                    h128fs_pkg::result_t w;
                    w = frame_words_due.pop_front();
                    words_checked++;
                    if (m_tdata[0] !== w.strobe)
                    begin
                        $error("strobe_level: expected %0b, actual %0b", w.strobe, m_tdata[0]);
                        error_count++;
                    end
                    if (m_tdata[1] !== w.frame)
                    begin
                        $error("frame_level: expected %0b, actual %0b", w.frame, m_tdata[1]);
                        error_count++;
                    end
                    if (m_tdata[2] !== w.data)
                    begin
                        $error("data_level: expected %0b, actual %0b", w.data, m_tdata[2]);
                        error_count++;
                    end
                    if (m_tdata[7:3] !== w.pos)
                    begin
                        $error("bit_position: expected %0d, actual %0d", w.pos, m_tdata[7:3]);
                        error_count++;
                    end
                    if (m_tlast !== w.last)
                    begin
                        $error("last_bit: expected %0b, actual %0b", w.last, m_tlast);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_frame(s_tdata);
                bytes_sent++;
            end
        end
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Called at a falling edge; returns at a falling edge with s_tvalid still
    // high, so back-to-back words need no second assignment in one step.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_byte(8'($urandom));
        end
    endtask

    // Holds the sender off until every expected word has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (frame_words_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic test_directed();
        logic [7:0] patterns[$];
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        // The first frame after reset shows a low data line during sync; a
        // frame ending in a one carries a high level into the next sync.
        patterns = '{8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h0F, 8'hF0};
        for (int i = 0; i < 8; i++)
        begin
            patterns.push_back(8'(1 << i));
            patterns.push_back(~8'(1 << i));
        end
        foreach (patterns[i])
        begin
            send_byte(patterns[i]);
        end
        wait_drained();
    endtask

    task automatic test_no_idling();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_random(65);
    endtask

    task automatic test_sparse_sender();
        sender_idle_pct    = 76;
        receiver_stall_pct = 0;
        send_random(65);
    endtask

    task automatic test_stalled_receiver();
        sender_idle_pct    = 0;
        receiver_stall_pct = 76;
        send_random(65);
        wait_drained();
    endtask

    task automatic test_both_idle();
        sender_idle_pct    = 8;
        receiver_stall_pct = 8;
        send_random(65);
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_no_idling();
        test_sparse_sender();
        test_stalled_receiver();
        test_both_idle();
        wait_drained();
        receiver_stall_pct = 0;
        repeat (20) @(negedge clk);
        $display("Sent %0d bytes (directed patterns and random bytes) and checked %0d frame words",
                 bytes_sent, words_checked);
        $display("under back-to-back traffic, sparse sender, stalled receiver and light idling.");
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d frame words still expected.", frame_words_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/h128fs_pkg.sv
design/h128fs_front.sv
design/h128fs_queue.sv
design/h128fs_back.sv
design/hamming_12_8_frame_serializer.sv
design/h128fs_checker.sv
dv/testbench.sv
